// ===== rtl/mips_integer_execute_defines.svh =====
// Assertion helpers shared by the execute block.
`ifndef MIPS_INTEGER_EXECUTE_DEFINES_SVH
`define MIPS_INTEGER_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MIE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mie_pkg.sv =====
`default_nettype none

package mie_pkg;

   // Operation codes as delivered by the decoder.
   typedef enum logic [5:0] {
      OP_NOP, OP_J, OP_JAL, OP_JR, OP_JALR, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
      OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU,
      OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU, OP_MULT, OP_MULTU,
      OP_MFHI, OP_MFLO, OP_MTHI, OP_MTLO, OP_DIV, OP_DIVU, OP_SLL, OP_SRL,
      OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_LW, OP_SW, OP_LB, OP_LH, OP_LBU,
      OP_LHU, OP_SB, OP_SH, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
      OP_ORI, OP_XORI, OP_LUI, OP_SYSCALL
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MRD, S_EXEC, S_MUL, S_DIV, S_WB
   } state_type;

   localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
   localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
   localparam logic [31:0] EXIT_CODE      = 32'h0000_000A;
   localparam logic [4:0]  LINK_REG       = 5'd31;
   localparam logic [4:0]  SYSCALL_REG    = 5'd2;

endpackage

`default_nettype wire

// ===== rtl/mips_integer_execute.sv =====
// Channel     | Direction | Signals
// ------------+-----------+--------------------------------------------------
// request     | in        | req_valid/req_ready, req_type and operand fields
// response    | out       | rsp_valid/rsp_ready, new PC, register/memory writes
// csr         | in        | csr_we/csr_wdata, loads start PC and the PC
//
// An instruction passes through read, memory read, execute, write back and idle;
// multiplies add a multiply step, divides by nonzero a divider pass (one quotient bit a
// cycle in the shared divider); memory operations add a divider pass too when DMEM_WORDS
// is not a power of two, since the word index is then reduced by the same divider.
// After reset the data memory is cleared one word a cycle, during which no request is
// accepted. A finished result waits in the output register; the next request is
// accepted meanwhile and only write back stalls.

`default_nettype none
`include "mips_integer_execute_defines.svh"

module mips_integer_execute
   import mie_pkg::*;
#(
   parameter int DMEM_WORDS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [5:0]         req_type,
   input  wire logic [4:0]         req_src_reg_a,
   input  wire logic [4:0]         req_src_reg_b,
   input  wire logic [4:0]         req_dest_reg,
   input  wire logic [4:0]         req_shift_amount,
   input  wire logic signed [15:0] req_immediate,
   input  wire logic [25:0]        req_jump_target,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_new_pc,
   output logic                    rsp_reg_written,
   output logic [4:0]              rsp_written_index,
   output logic [31:0]             rsp_written_value,
   output logic                    rsp_mem_written,
   output logic [31:0]             rsp_mem_address,
   output logic [31:0]             rsp_mem_word,
   output logic                    rsp_halted,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_wdata
);

   localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
   localparam bit DMEM_POW2 = ((DMEM_WORDS & (DMEM_WORDS - 1)) == 0);
   localparam logic [AW-1:0] LAST_WORD = AW'(DMEM_WORDS - 1);

   // Storage.
   logic [31:0] rf_mem [32];
   logic [31:0] dmem [DMEM_WORDS];

   // Control state.
   state_type   state_ff, state_in;
   logic        clr_busy_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        halt_ff;
   logic [31:0] pc_ff, start_pc_ff, hi_ff, lo_ff;
   logic [31:0] rf_valid_ff;

   // Instruction and working registers.
   op_type      op_ff, op_in;
   logic [4:0]  ra_ff, ra_in, rb_ff, rb_in, rd_ff, rd_in, sa_ff, sa_in;
   logic [15:0] imm_ff, imm_in;
   logic [25:0] tgt_ff, tgt_in;
   logic [31:0] rf_qa_ff, rf_qb_ff, dm_q_ff;
   logic [31:0] ea_ff, ea_in;
   logic [AW-1:0] dm_idx_ff, dm_idx_in;
   logic [63:0] prod_ff, prod_in;

   // Divider.
   logic [31:0] div_rem_ff, div_rem_in, div_quo_ff, div_quo_in, div_dvs_ff, div_dvs_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic        div_idx_ff, div_idx_in, div_negq_ff, div_negq_in, div_negr_ff, div_negr_in;

   // Pending result.
   logic [31:0] res_pc_ff, res_pc_in, res_val_ff, res_val_in;
   logic [31:0] res_addr_ff, res_addr_in, res_word_ff, res_word_in;
   logic [31:0] res_hi_ff, res_hi_in, res_lo_ff, res_lo_in;
   logic [4:0]  res_idx_ff, res_idx_in;
   logic        res_wr_ff, res_wr_in, res_mw_ff, res_mw_in, res_halt_ff, res_halt_in;
   logic        res_hilo_ff, res_hilo_in;

   // Output register.
   logic [31:0] out_pc_ff, out_val_ff, out_addr_ff, out_word_ff;
   logic [4:0]  out_idx_ff;
   logic        out_wr_ff, out_mw_ff, out_halt_ff;

   logic        accept, wb_go;
   logic [31:0] a_val, b_val, simm, pc4, btarget, w_b, w_h, wval;
   logic [4:0]  bsh, hsh, widx;
   logic        has_wr, a_neg;
   logic [32:0] div_trial;
   logic [31:0] div_rem_nx, div_quo_nx;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_full;
   logic        dm_we;
   logic [AW-1:0] dm_waddr;
   logic [31:0] dm_wdata;
   logic [4:0]  rf_raddr_a;

   assign req_ready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign accept    = req_valid && req_ready;
   assign wb_go     = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);

   // Register operands; an entry never written since reset reads as zero.
   assign a_val = rf_valid_ff[ra_ff] ? rf_qa_ff : 32'd0;
   assign b_val = rf_valid_ff[rb_ff] ? rf_qb_ff : 32'd0;
   assign a_neg = a_val[31];
   assign simm  = {{16{imm_ff[15]}}, imm_ff};
   assign pc4   = pc_ff + 32'd4;
   assign btarget = pc4 + {simm[29:0], 2'b00};

   // Byte and halfword lanes of the loaded word.
   assign bsh = {ea_ff[1:0], 3'b000};
   assign hsh = {ea_ff[1], 4'b0000};
   assign w_b = dm_q_ff >> bsh;
   assign w_h = dm_q_ff >> hsh;

   // One divide step: shift in the next dividend bit and try to subtract.
   assign div_trial = {div_rem_ff, div_quo_ff[31]} - {1'b0, div_dvs_ff};
   always_comb begin
      if (!div_trial[32]) begin
         div_rem_nx = div_trial[31:0];
         div_quo_nx = {div_quo_ff[30:0], 1'b1};
      end else begin
         div_rem_nx = {div_rem_ff[30:0], div_quo_ff[31]};
         div_quo_nx = {div_quo_ff[30:0], 1'b0};
      end
   end

   // Multiplier operands, sign- or zero-extended to 33 bits.
   assign mul_a = {(op_ff == OP_MULT) & a_val[31], a_val};
   assign mul_b = {(op_ff == OP_MULT) & b_val[31], b_val};
   assign prod_full = mul_a * mul_b;

   // Sequencer, execute datapath and result capture.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rd_in       = rd_ff;
      sa_in       = sa_ff;
      imm_in      = imm_ff;
      tgt_in      = tgt_ff;
      ea_in       = ea_ff;
      dm_idx_in   = dm_idx_ff;
      prod_in     = prod_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_dvs_in  = div_dvs_ff;
      div_cnt_in  = div_cnt_ff;
      div_idx_in  = div_idx_ff;
      div_negq_in = div_negq_ff;
      div_negr_in = div_negr_ff;
      res_pc_in   = res_pc_ff;
      res_val_in  = res_val_ff;
      res_idx_in  = res_idx_ff;
      res_wr_in   = res_wr_ff;
      res_mw_in   = res_mw_ff;
      res_addr_in = res_addr_ff;
      res_word_in = res_word_ff;
      res_halt_in = res_halt_ff;
      res_hi_in   = res_hi_ff;
      res_lo_in   = res_lo_ff;
      res_hilo_in = res_hilo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      has_wr      = 1'b0;
      widx        = 5'd0;
      wval        = 32'd0;
      rf_raddr_a  = (op_type'(req_type) == OP_SYSCALL) ? SYSCALL_REG : req_src_reg_a;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_type);
               ra_in    = rf_raddr_a;
               rb_in    = req_src_reg_b;
               rd_in    = req_dest_reg;
               sa_in    = req_shift_amount;
               imm_in   = req_immediate;
               tgt_in   = req_jump_target;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Effective address, then the word index into data memory.
            ea_in = a_val + simm;
            if (DMEM_POW2 || halt_ff || !(op_ff inside {[OP_LW:OP_SH]})) begin
               dm_idx_in = ea_in[2 +: AW];
               state_in  = S_MRD;
            end else begin
               div_rem_in = 32'd0;
               div_quo_in = {2'b00, ea_in[31:2]};
               div_dvs_in = 32'(DMEM_WORDS);
               div_cnt_in = 5'd0;
               div_idx_in = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_MRD: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_pc_in   = pc4;
            res_mw_in   = 1'b0;
            res_addr_in = 32'd0;
            res_word_in = 32'd0;
            res_hilo_in = 1'b0;
            res_halt_in = halt_ff;
            state_in    = S_WB;
            if (halt_ff) begin
               res_pc_in = pc_ff;
            end else begin
               case (op_ff)
                  OP_J: res_pc_in = (pc4 & PC_REGION_MASK) | {4'b0000, tgt_ff, 2'b00};
                  OP_JAL: begin
                     res_pc_in = (pc4 & PC_REGION_MASK) | {4'b0000, tgt_ff, 2'b00};
                     has_wr = 1'b1; widx = LINK_REG; wval = pc4;
                  end
                  OP_JR: res_pc_in = a_val;
                  OP_JALR: begin
                     res_pc_in = a_val;
                     has_wr = 1'b1; widx = (rd_ff != 5'd0) ? rd_ff : LINK_REG; wval = pc4;
                  end
                  OP_BEQ:  if (a_val == b_val) res_pc_in = btarget;
                  OP_BNE:  if (a_val != b_val) res_pc_in = btarget;
                  OP_BLEZ: if (a_neg || a_val == 32'd0) res_pc_in = btarget;
                  OP_BGTZ: if (!a_neg && a_val != 32'd0) res_pc_in = btarget;
                  OP_BLTZ: if (a_neg) res_pc_in = btarget;
                  OP_BGEZ: if (!a_neg) res_pc_in = btarget;
                  OP_BLTZAL: begin
                     if (a_neg) res_pc_in = btarget;
                     has_wr = 1'b1; widx = LINK_REG; wval = pc4;
                  end
                  OP_BGEZAL: begin
                     if (!a_neg) res_pc_in = btarget;
                     has_wr = 1'b1; widx = LINK_REG; wval = pc4;
                  end
                  OP_ADD, OP_ADDU: begin has_wr = 1'b1; widx = rd_ff; wval = a_val + b_val; end
                  OP_SUB, OP_SUBU: begin has_wr = 1'b1; widx = rd_ff; wval = a_val - b_val; end
                  OP_AND: begin has_wr = 1'b1; widx = rd_ff; wval = a_val & b_val; end
                  OP_OR:  begin has_wr = 1'b1; widx = rd_ff; wval = a_val | b_val; end
                  OP_XOR: begin has_wr = 1'b1; widx = rd_ff; wval = a_val ^ b_val; end
                  OP_NOR: begin has_wr = 1'b1; widx = rd_ff; wval = ~(a_val | b_val); end
                  OP_SLT: begin
                     has_wr = 1'b1; widx = rd_ff;
                     wval = {31'd0, $signed(a_val) < $signed(b_val)};
                  end
                  OP_SLTU: begin has_wr = 1'b1; widx = rd_ff; wval = {31'd0, a_val < b_val}; end
                  OP_MULT, OP_MULTU: begin
                     prod_in  = prod_full[63:0];
                     state_in = S_MUL;
                  end
                  OP_MFHI: begin has_wr = 1'b1; widx = rd_ff; wval = hi_ff; end
                  OP_MFLO: begin has_wr = 1'b1; widx = rd_ff; wval = lo_ff; end
                  OP_MTHI: begin res_hilo_in = 1'b1; res_hi_in = a_val; res_lo_in = lo_ff; end
                  OP_MTLO: begin res_hilo_in = 1'b1; res_hi_in = hi_ff; res_lo_in = a_val; end
                  OP_DIV, OP_DIVU: begin
                     if (b_val != 32'd0) begin
                        div_negq_in = (op_ff == OP_DIV) && (a_val[31] != b_val[31]);
                        div_negr_in = (op_ff == OP_DIV) && a_val[31];
                        div_quo_in  = ((op_ff == OP_DIV) && a_val[31]) ? 32'd0 - a_val : a_val;
                        div_dvs_in  = ((op_ff == OP_DIV) && b_val[31]) ? 32'd0 - b_val : b_val;
                        div_rem_in  = 32'd0;
                        div_cnt_in  = 5'd0;
                        div_idx_in  = 1'b0;
                        state_in    = S_DIV;
                     end
                  end
                  OP_SLL:  begin has_wr = 1'b1; widx = rd_ff; wval = b_val << sa_ff; end
                  OP_SRL:  begin has_wr = 1'b1; widx = rd_ff; wval = b_val >> sa_ff; end
                  OP_SRA:  begin has_wr = 1'b1; widx = rd_ff; wval = $signed(b_val) >>> sa_ff; end
                  OP_SLLV: begin has_wr = 1'b1; widx = rd_ff; wval = b_val << a_val[4:0]; end
                  OP_SRLV: begin has_wr = 1'b1; widx = rd_ff; wval = b_val >> a_val[4:0]; end
                  OP_SRAV: begin
                     has_wr = 1'b1; widx = rd_ff; wval = $signed(b_val) >>> a_val[4:0];
                  end
                  OP_LW: begin
                     res_addr_in = ea_ff; has_wr = 1'b1; widx = rb_ff; wval = dm_q_ff;
                  end
                  OP_LB: begin
                     res_addr_in = ea_ff; has_wr = 1'b1; widx = rb_ff;
                     wval = {{24{w_b[7]}}, w_b[7:0]};
                  end
                  OP_LH: begin
                     res_addr_in = ea_ff; has_wr = 1'b1; widx = rb_ff;
                     wval = {{16{w_h[15]}}, w_h[15:0]};
                  end
                  OP_LBU: begin
                     res_addr_in = ea_ff; has_wr = 1'b1; widx = rb_ff; wval = {24'd0, w_b[7:0]};
                  end
                  OP_LHU: begin
                     res_addr_in = ea_ff; has_wr = 1'b1; widx = rb_ff; wval = {16'd0, w_h[15:0]};
                  end
                  OP_SW: begin res_addr_in = ea_ff; res_mw_in = 1'b1; res_word_in = b_val; end
                  OP_SB: begin
                     res_addr_in = ea_ff; res_mw_in = 1'b1;
                     res_word_in = (dm_q_ff & ~(32'h0000_00FF << bsh))
                                 | ({24'd0, b_val[7:0]} << bsh);
                  end
                  OP_SH: begin
                     res_addr_in = ea_ff; res_mw_in = 1'b1;
                     res_word_in = (dm_q_ff & ~(32'h0000_FFFF << hsh))
                                 | ({16'd0, b_val[15:0]} << hsh);
                  end
                  OP_ADDI, OP_ADDIU: begin has_wr = 1'b1; widx = rb_ff; wval = a_val + simm; end
                  OP_SLTI: begin
                     has_wr = 1'b1; widx = rb_ff;
                     wval = {31'd0, $signed(a_val) < $signed(simm)};
                  end
                  OP_SLTIU: begin has_wr = 1'b1; widx = rb_ff; wval = {31'd0, a_val < simm}; end
                  OP_ANDI: begin has_wr = 1'b1; widx = rb_ff; wval = a_val & {16'd0, imm_ff}; end
                  OP_ORI:  begin has_wr = 1'b1; widx = rb_ff; wval = a_val | {16'd0, imm_ff}; end
                  OP_XORI: begin has_wr = 1'b1; widx = rb_ff; wval = a_val ^ {16'd0, imm_ff}; end
                  OP_LUI:  begin has_wr = 1'b1; widx = rb_ff; wval = {imm_ff, 16'd0}; end
                  OP_SYSCALL: if (a_val == EXIT_CODE) res_halt_in = 1'b1;
                  default: ;
               endcase
            end
            // Writes to r0 are dropped and reported as no write.
            res_wr_in  = has_wr && (widx != 5'd0);
            res_idx_in = res_wr_in ? widx : 5'd0;
            res_val_in = res_wr_in ? wval : 32'd0;
         end
         S_MUL: begin
            res_hilo_in = 1'b1;
            res_hi_in   = prod_ff[63:32];
            res_lo_in   = prod_ff[31:0];
            state_in    = S_WB;
         end
         S_DIV: begin
            div_rem_in = div_rem_nx;
            div_quo_in = div_quo_nx;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               if (div_idx_ff) begin
                  dm_idx_in = div_rem_nx[AW-1:0];
                  state_in  = S_MRD;
               end else begin
                  res_hilo_in = 1'b1;
                  res_lo_in   = div_negq_ff ? 32'd0 - div_quo_nx : div_quo_nx;
                  res_hi_in   = div_negr_ff ? 32'd0 - div_rem_nx : div_rem_nx;
                  state_in    = S_WB;
               end
            end
         end
         S_WB: begin
            if (wb_go) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Data memory port: clearing pass after reset, else store write back.
   assign dm_we    = clr_busy_ff || (wb_go && res_mw_ff);
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff : dm_idx_ff;
   assign dm_wdata = clr_busy_ff ? 32'd0 : res_word_ff;

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_waddr] <= dm_wdata;
      end
      if (state_ff == S_MRD) begin
         dm_q_ff <= dmem[dm_idx_ff];
      end
   end

   // Register file: two read ports sampled at acceptance, one write port.
   always_ff @(posedge clock) begin
      if (wb_go && res_wr_ff) begin
         rf_mem[res_idx_ff] <= res_val_ff;
      end
      if (accept) begin
         rf_qa_ff <= rf_mem[rf_raddr_a];
         rf_qb_ff <= rf_mem[req_src_reg_b];
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         halt_ff      <= 1'b0;
         start_pc_ff  <= START_PC_RESET;
         pc_ff        <= START_PC_RESET;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
         rf_valid_ff  <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_WORD) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            start_pc_ff <= csr_wdata;
            pc_ff       <= csr_wdata;
         end else if (wb_go) begin
            pc_ff <= res_pc_ff;
         end
         if (wb_go) begin
            halt_ff <= res_halt_ff;
            if (res_hilo_ff) begin
               hi_ff <= res_hi_ff;
               lo_ff <= res_lo_ff;
            end
            if (res_wr_ff) begin
               rf_valid_ff[res_idx_ff] <= 1'b1;
            end
         end
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rd_ff       <= rd_in;
      sa_ff       <= sa_in;
      imm_ff      <= imm_in;
      tgt_ff      <= tgt_in;
      ea_ff       <= ea_in;
      dm_idx_ff   <= dm_idx_in;
      prod_ff     <= prod_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dvs_ff  <= div_dvs_in;
      div_cnt_ff  <= div_cnt_in;
      div_idx_ff  <= div_idx_in;
      div_negq_ff <= div_negq_in;
      div_negr_ff <= div_negr_in;
      res_pc_ff   <= res_pc_in;
      res_val_ff  <= res_val_in;
      res_idx_ff  <= res_idx_in;
      res_wr_ff   <= res_wr_in;
      res_mw_ff   <= res_mw_in;
      res_addr_ff <= res_addr_in;
      res_word_ff <= res_word_in;
      res_halt_ff <= res_halt_in;
      res_hi_ff   <= res_hi_in;
      res_lo_ff   <= res_lo_in;
      res_hilo_ff <= res_hilo_in;
      if (wb_go) begin
         out_pc_ff   <= res_pc_ff;
         out_wr_ff   <= res_wr_ff;
         out_idx_ff  <= res_idx_ff;
         out_val_ff  <= res_val_ff;
         out_mw_ff   <= res_mw_ff;
         out_addr_ff <= res_addr_ff;
         out_word_ff <= res_word_ff;
         out_halt_ff <= res_halt_ff;
      end
   end

   // Response ports.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_pc        = out_pc_ff;
   assign rsp_reg_written   = out_wr_ff;
   assign rsp_written_index = out_idx_ff;
   assign rsp_written_value = out_val_ff;
   assign rsp_mem_written   = out_mw_ff;
   assign rsp_mem_address   = out_addr_ff;
   assign rsp_mem_word      = out_word_ff;
   assign rsp_halted        = out_halt_ff;

   // A transaction is only taken when the sequencer is idle and memory is cleared.
   `MIE_ASSERT_NOW(a_accept_idle, clock, reset, req_valid && req_ready, (state_ff == S_IDLE) && !clr_busy_ff, "request accepted while busy")
   // Write back always leaves a response waiting.
   `MIE_ASSERT_NEXT(a_wb_resp, clock, reset, wb_go, rsp_valid_ff && (state_ff == S_IDLE), "write back lost its response")
   // r0 is never reported as written.
   `MIE_ASSERT_NOW(a_no_r0, clock, reset, rsp_valid && rsp_reg_written, rsp_written_index != 5'd0, "write to r0 reported")
   // The halt flag is sticky.
   `MIE_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt flag cleared")

endmodule

`default_nettype wire
